// ===== src/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation pipeline.
// Used by every module of the block but bpc_div; depends on nothing else.
`default_nettype none

package bpc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COEFF_A = 2'd0;
	localparam logic [1:0] CFG_COEFF_B = 2'd1;
	localparam logic [1:0] CFG_COEFF_C = 2'd2;
	localparam logic [1:0] CFG_OVERSAMPLING = 2'd3;

	// Compensation constants.
	localparam int TEMP_OFFSET = 4000;
	localparam int P_C1 = 3038;
	localparam int P_C2 = 7357;
	localparam int P_C3 = 3791;
	localparam int SCALE_BASE = 50000;
	localparam int X3_BIAS = 32768;
	localparam int RAW_SHIFT_MAX = 8;
	localparam int TEMP_MAX = 32767;
	localparam int TEMP_MIN = -32768;
	localparam int PRESS_MAX = 1048575;

	// Divider geometry.
	localparam int DIV1_NUM_W = 27;
	localparam int DIV1_DEN_W = 18;
	localparam int DIV2_NUM_W = 32;
	localparam int DIV2_DEN_W = 17;

	typedef struct packed {
		logic [15:0] temp_raw;
		logic [7:0]  press_msb;
		logic [7:0]  press_lsb;
		logic [7:0]  press_xlsb;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] temp_tenths;
		logic [19:0]        press_pascal;
		logic               div_fault;
	} out_item_t;

	// Calibration values unpacked from the configuration words.
	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic [1:0]         oss;
	} coeff_t;

	// Data that rides alongside the temperature division.
	typedef struct packed {
		logic signed [17:0] x1;
		logic               qneg;
		logic               fault;
		logic [23:0]        up;
	} div1_side_t;

	// Data that rides alongside the pressure division.
	typedef struct packed {
		logic signed [15:0] t;
		logic               fault;
		logic               wide;
	} div2_side_t;

	// Signed division by two to the k, truncating toward zero.
	function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] v,
		input int unsigned k);
		logic signed [63:0] bias;
		bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (v + bias) >>> k;
	endfunction

endpackage

`default_nettype wire

// ===== src/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation pipeline: configuration registers,
// global advance control and the chain of front, dividers, middle and back stages.
// Depends on bpc_pkg, bpc_front, bpc_div, bpc_mid and bpc_back.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   in_data   (temp_raw, press_msb, press_lsb, press_xlsb)
//   out       out_valid / out_stall out_data  (temp_tenths, press_pascal, div_fault)
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request enters per cycle while in_stall is low; each result passes through 2 front stages,
// 27 stages of the temperature divider, 8 middle stages, 32 stages of the pressure
// divider and 3 back stages. The two bit-per-stage dividers make up most of these stages.
// Reset clears all valid bits and the calibration registers. When a result waits
// under out_stall the whole pipeline holds and in_stall is raised.
`default_nettype none

module barometric_pressure_compensation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire bpc_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output bpc_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	logic [63:0] coeff_a_q;
	logic [63:0] coeff_b_q;
	logic [31:0] coeff_c_q;
	logic [1:0]  oss_q;

	bpc_pkg::coeff_t     coeff;
	logic                en;

	logic                         f_valid;
	logic [bpc_pkg::DIV1_NUM_W-1:0] f_num;
	logic [bpc_pkg::DIV1_DEN_W-1:0] f_den;
	bpc_pkg::div1_side_t          f_side;

	logic                         d1_valid;
	logic [bpc_pkg::DIV1_NUM_W-1:0] d1_quo;
	bpc_pkg::div1_side_t          d1_side;

	logic                         m_valid;
	logic [bpc_pkg::DIV2_NUM_W-1:0] m_num;
	logic [bpc_pkg::DIV2_DEN_W-1:0] m_den;
	bpc_pkg::div2_side_t          m_side;

	logic                         d2_valid;
	logic [bpc_pkg::DIV2_NUM_W-1:0] d2_quo;
	bpc_pkg::div2_side_t          d2_side;

	// The whole pipeline advances unless a finished result is held.
	assign en = ~out_valid | ~out_stall;
	assign in_stall = ~en;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= '0;
			coeff_b_q <= '0;
			coeff_c_q <= '0;
			oss_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bpc_pkg::CFG_COEFF_A: coeff_a_q <= cfg_data;
				bpc_pkg::CFG_COEFF_B: coeff_b_q <= cfg_data;
				bpc_pkg::CFG_COEFF_C: coeff_c_q <= cfg_data[31:0];
				bpc_pkg::CFG_OVERSAMPLING: oss_q <= cfg_data[1:0];
				default: oss_q <= oss_q;
			endcase
		end
	end

	// Unpack the calibration words.
	always_comb begin
		coeff.ac1 = coeff_a_q[15:0];
		coeff.ac2 = coeff_a_q[31:16];
		coeff.ac3 = coeff_a_q[47:32];
		coeff.ac4 = coeff_a_q[63:48];
		coeff.ac5 = coeff_b_q[15:0];
		coeff.ac6 = coeff_b_q[31:16];
		coeff.b1 = coeff_b_q[47:32];
		coeff.b2 = coeff_b_q[63:48];
		coeff.mc = coeff_c_q[15:0];
		coeff.md = coeff_c_q[31:16];
		coeff.oss = oss_q;
	end

	bpc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .item(in_data), .coeff(coeff),
		.out_valid(f_valid), .num(f_num), .den(f_den), .side(f_side)
	);

	bpc_div #(
		.NUM_W(bpc_pkg::DIV1_NUM_W),
		.DEN_W(bpc_pkg::DIV1_DEN_W),
		.SIDE_W($bits(bpc_pkg::div1_side_t))
	) u_div_temp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .num(f_num), .den(f_den), .side(f_side),
		.out_valid(d1_valid), .quo(d1_quo), .out_side(d1_side)
	);

	bpc_mid u_mid (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d1_valid), .q1(d1_quo), .side1(d1_side), .coeff(coeff),
		.out_valid(m_valid), .num(m_num), .den(m_den), .side(m_side)
	);

	bpc_div #(
		.NUM_W(bpc_pkg::DIV2_NUM_W),
		.DEN_W(bpc_pkg::DIV2_DEN_W),
		.SIDE_W($bits(bpc_pkg::div2_side_t))
	) u_div_press (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(m_valid), .num(m_num), .den(m_den), .side(m_side),
		.out_valid(d2_valid), .quo(d2_quo), .out_side(d2_side)
	);

	bpc_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d2_valid), .q2(d2_quo), .side2(d2_side),
		.out_valid(out_valid), .result(out_data)
	);

endmodule

`default_nettype wire

// ===== src/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on nothing; used twice by the compensation pipeline.
`default_nettype none

module bpc_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 17,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side,
	output logic                   out_valid,
	output logic [NUM_W-1:0]       quo,
	output logic [SIDE_W-1:0]      out_side
);

	// Each stage holds {partial remainder, dividend bits and quotient bits}.
	logic [NUM_W-1:0]       vld_s;
	logic [DEN_W+NUM_W-1:0] acc_s  [NUM_W];
	logic [DEN_W-1:0]       den_s  [NUM_W];
	logic [SIDE_W-1:0]      side_s [NUM_W];

	genvar gi;
	generate
		for (gi = 0; gi < NUM_W; gi++) begin : g_stage
			logic                   vin;
			logic [DEN_W+NUM_W-1:0] acc_in;
			logic [DEN_W-1:0]       den_in;
			logic [SIDE_W-1:0]      side_in;
			logic [DEN_W+NUM_W:0]   sh;
			logic [DEN_W:0]         top;
			logic [DEN_W+1:0]       diff;
			logic                   ge;
			logic [DEN_W-1:0]       rem;

			// Pick the previous stage, or the ports for the first one.
			if (gi == 0) begin : g_first
				assign vin = in_valid;
				assign acc_in = {{DEN_W{1'b0}}, num};
				assign den_in = den;
				assign side_in = side;
			end else begin : g_next
				assign vin = vld_s[gi-1];
				assign acc_in = acc_s[gi-1];
				assign den_in = den_s[gi-1];
				assign side_in = side_s[gi-1];
			end

			// Shift in one dividend bit and subtract the divisor when it fits.
			always_comb begin
				sh = {acc_in, 1'b0};
				top = sh[DEN_W+NUM_W:NUM_W];
				diff = {1'b0, top} - {2'b00, den_in};
				ge = ~diff[DEN_W+1];
				rem = ge ? diff[DEN_W-1:0] : top[DEN_W-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[gi] <= 1'b0;
				end else if (en) begin
					vld_s[gi] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[gi] <= {rem, sh[NUM_W-1:1], ge};
					den_s[gi] <= den_in;
					side_s[gi] <= side_in;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NUM_W-1];
	assign quo = acc_s[NUM_W-1][NUM_W-1:0];
	assign out_side = side_s[NUM_W-1];

endmodule

`default_nettype wire

// ===== src/bpc_front.sv =====
// Front stages: raw pressure alignment, first temperature term and divider operands.
// Depends on bpc_pkg.
`default_nettype none

module bpc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire bpc_pkg::in_item_t   item,
	input  wire bpc_pkg::coeff_t     coeff,
	output logic                     out_valid,
	output logic [bpc_pkg::DIV1_NUM_W-1:0] num,
	output logic [bpc_pkg::DIV1_DEN_W-1:0] den,
	output bpc_pkg::div1_side_t      side
);

	logic                 v_s1;
	logic signed [33:0]   prod_s1;
	logic [23:0]          up_s1;

	logic signed [16:0]   ut_d;
	logic [23:0]          raw;
	logic [3:0]           shamt;

	logic signed [63:0]   x1_w;
	logic signed [17:0]   x1;
	logic signed [18:0]   den_sgn;
	logic signed [26:0]   num_sgn;

	// Stage 1: (ut - ac6) * ac5 and the uncompensated pressure word.
	always_comb begin
		ut_d = $signed({1'b0, item.temp_raw}) - $signed({1'b0, coeff.ac6});
		raw = {item.press_msb, item.press_lsb, item.press_xlsb};
		shamt = 4'(bpc_pkg::RAW_SHIFT_MAX) - {2'b00, coeff.oss};
	end

	// Stage 2: x1, the signed divisor x1 + md and the dividend mc * 2048.
	always_comb begin
		x1_w = bpc_pkg::sdiv_pow2(64'(prod_s1), 15);
		x1 = x1_w[17:0];
		den_sgn = 19'(x1) + 19'(coeff.md);
		num_sgn = {coeff.mc, 11'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ut_d * $signed({1'b0, coeff.ac5});
			up_s1 <= raw >> shamt;
			num <= num_sgn[26] ? 27'(-num_sgn) : 27'(num_sgn);
			den <= den_sgn[18] ? 18'(-den_sgn) : 18'(den_sgn);
			side.x1 <= x1;
			side.qneg <= num_sgn[26] ^ den_sgn[18];
			side.fault <= (den_sgn == 19'sd0);
			side.up <= up_s1;
		end
	end

endmodule

`default_nettype wire

// ===== src/bpc_mid.sv =====
// Middle stages: temperature result, B3, B4 and B7, and the pressure divider operands.
// Depends on bpc_pkg.
`default_nettype none

module bpc_mid (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [bpc_pkg::DIV1_NUM_W-1:0] q1,
	input  wire bpc_pkg::div1_side_t       side1,
	input  wire bpc_pkg::coeff_t           coeff,
	output logic                           out_valid,
	output logic [bpc_pkg::DIV2_NUM_W-1:0] num,
	output logic [bpc_pkg::DIV2_DEN_W-1:0] den,
	output bpc_pkg::div2_side_t            side
);

	logic [7:1] v_s;

	logic signed [28:0] b5_s1;
	logic [23:0]        up_s1, up_s2, up_s3, up_s4, up_s5, up_s6;
	logic               f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7;
	logic signed [15:0] t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic signed [57:0] bb_s2;
	logic signed [44:0] pac2_s2, pac3_s2;
	logic signed [39:0] b2hi_s3, b2lo_s3, b1hi_s3, b1lo_s3;
	logic signed [33:0] x2a_s3, x2a_s4;
	logic signed [31:0] x1c_s3, x1c_s4;
	logic signed [63:0] b2sq_s4, b1sq_s4;
	logic signed [53:0] x3_s5;
	logic signed [47:0] s_s5;
	logic [31:0]        b3lo_s6, xb_s6;
	logic [16:0]        b4_s7;
	logic [31:0]        diff_s7;

	logic signed [27:0] x2;
	logic signed [28:0] b6;
	logic signed [63:0] tv;
	logic signed [15:0] t_sat;
	logic [45:0]        sq;
	logic signed [63:0] x2a_w, x1c_w, x3_w, s_w, acc_w, b3_w, x3p_w;
	logic [47:0]        b4_prod, b7_prod;
	logic [15:0]        scale;
	logic [31:0]        b7;

	// M1: apply the quotient sign, B5 = x1 + x2.
	assign x2 = side1.qneg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

	// M2: temperature, B6 and the products that use B6.
	always_comb begin
		b6 = b5_s1 - 29'(bpc_pkg::TEMP_OFFSET);
		tv = bpc_pkg::sdiv_pow2(64'(b5_s1) + 64'sd8, 4);
		if (tv > 64'(bpc_pkg::TEMP_MAX)) begin
			t_sat = 16'(bpc_pkg::TEMP_MAX);
		end else if (tv < 64'(bpc_pkg::TEMP_MIN)) begin
			t_sat = 16'(bpc_pkg::TEMP_MIN);
		end else begin
			t_sat = tv[15:0];
		end
	end

	// M3: split B6^2/4096 into halves for the b1 and b2 products.
	always_comb begin
		sq = bb_s2[57:12];
		x2a_w = bpc_pkg::sdiv_pow2(64'(pac2_s2), 11);
		x1c_w = bpc_pkg::sdiv_pow2(64'(pac3_s2), 13);
	end

	// M5: X3 for B3, and the sum for the B4 term.
	always_comb begin
		x3_w = bpc_pkg::sdiv_pow2(b2sq_s4, 11) + 64'(x2a_s4);
		s_w = bpc_pkg::sdiv_pow2(b1sq_s4, 16) + 64'(x1c_s4);
	end

	// M6: B3 and the B4 multiplicand, both kept to 32 bits.
	always_comb begin
		acc_w = (64'(coeff.ac1) <<< 2) + 64'(x3_s5);
		b3_w = bpc_pkg::sdiv_pow2((acc_w <<< coeff.oss) + 64'sd2, 2);
		x3p_w = bpc_pkg::sdiv_pow2(64'(s_s5) + 64'sd2, 2);
	end

	// M7 and M8: B4, B7 and the divider operands.
	always_comb begin
		b4_prod = 48'(coeff.ac4) * 48'(xb_s6);
		scale = 16'(bpc_pkg::SCALE_BASE >> coeff.oss);
		b7_prod = 48'(diff_s7) * 48'(scale);
		b7 = b7_prod[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s <= {v_s[6:1], in_valid};
			out_valid <= v_s[7];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s1 <= 29'(side1.x1) + 29'(x2);
			up_s1 <= side1.up;
			f_s1 <= side1.fault;

			t_s2 <= t_sat;
			bb_s2 <= b6 * b6;
			pac2_s2 <= 45'(coeff.ac2) * 45'(b6);
			pac3_s2 <= 45'(coeff.ac3) * 45'(b6);
			up_s2 <= up_s1;
			f_s2 <= f_s1;

			b2hi_s3 <= coeff.b2 * $signed({1'b0, sq[45:23]});
			b2lo_s3 <= coeff.b2 * $signed({1'b0, sq[22:0]});
			b1hi_s3 <= coeff.b1 * $signed({1'b0, sq[45:23]});
			b1lo_s3 <= coeff.b1 * $signed({1'b0, sq[22:0]});
			x2a_s3 <= x2a_w[33:0];
			x1c_s3 <= x1c_w[31:0];
			t_s3 <= t_s2;
			up_s3 <= up_s2;
			f_s3 <= f_s2;

			b2sq_s4 <= (64'(b2hi_s3) <<< 23) + 64'(b2lo_s3);
			b1sq_s4 <= (64'(b1hi_s3) <<< 23) + 64'(b1lo_s3);
			x2a_s4 <= x2a_s3;
			x1c_s4 <= x1c_s3;
			t_s4 <= t_s3;
			up_s4 <= up_s3;
			f_s4 <= f_s3;

			x3_s5 <= x3_w[53:0];
			s_s5 <= s_w[47:0];
			t_s5 <= t_s4;
			up_s5 <= up_s4;
			f_s5 <= f_s4;

			b3lo_s6 <= b3_w[31:0];
			xb_s6 <= x3p_w[31:0] + 32'(bpc_pkg::X3_BIAS);
			t_s6 <= t_s5;
			up_s6 <= up_s5;
			f_s6 <= f_s5;

			b4_s7 <= b4_prod[31:15];
			diff_s7 <= {8'b0, up_s6} - b3lo_s6;
			t_s7 <= t_s6;
			f_s7 <= f_s6;

			// The sign bit of B7 picks between doubling before or after dividing.
			num <= b7[31] ? b7 : {b7[30:0], 1'b0};
			den <= b4_s7;
			side.t <= t_s7;
			side.fault <= f_s7 | (b4_s7 == 17'd0);
			side.wide <= b7[31];
		end
	end

endmodule

`default_nettype wire

// ===== src/bpc_back.sv =====
// Back stages: pressure correction polynomial, saturation and the result register.
// Depends on bpc_pkg.
`default_nettype none

module bpc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [bpc_pkg::DIV2_NUM_W-1:0] q2,
	input  wire bpc_pkg::div2_side_t       side2,
	output logic                           out_valid,
	output bpc_pkg::out_item_t             result
);

	logic               v_s1, v_s2;
	logic [32:0]        p_s1, p_s2;
	logic [49:0]        sq2_s1;
	logic [45:0]        m2_s1;
	logic [45:0]        x1_s2;
	logic [29:0]        x2m_s2;
	logic signed [15:0] t_s1, t_s2;
	logic               f_s1, f_s2;

	logic [32:0]        p;
	logic [61:0]        m1;
	logic signed [63:0] sum, pf;
	logic [19:0]        p_sat;

	// B1: undo the halving of wide B7 values, then p/256 squared and 7357 * p.
	assign p = side2.wide ? {q2, 1'b0} : {1'b0, q2};

	// B2: scale the square term.
	assign m1 = 62'(sq2_s1) * 62'(bpc_pkg::P_C1);

	// B3: final correction and saturation.
	always_comb begin
		sum = $signed({18'b0, x1_s2}) - $signed({34'b0, x2m_s2}) + 64'(bpc_pkg::P_C3);
		pf = $signed({31'b0, p_s2}) + bpc_pkg::sdiv_pow2(sum, 4);
		if (pf < 64'sd0) begin
			p_sat = 20'd0;
		end else if (pf > 64'(bpc_pkg::PRESS_MAX)) begin
			p_sat = 20'(bpc_pkg::PRESS_MAX);
		end else begin
			p_sat = pf[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p;
			sq2_s1 <= 50'(p[32:8]) * 50'(p[32:8]);
			m2_s1 <= 46'(p) * 46'(bpc_pkg::P_C2);
			t_s1 <= side2.t;
			f_s1 <= side2.fault;

			p_s2 <= p_s1;
			x1_s2 <= m1[61:16];
			x2m_s2 <= m2_s1[45:16];
			t_s2 <= t_s1;
			f_s2 <= f_s1;

			// A zero divisor anywhere clears both results.
			result.temp_tenths <= f_s2 ? 16'sd0 : t_s2;
			result.press_pascal <= f_s2 ? 20'd0 : p_sat;
			result.div_fault <= f_s2;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/barometric_pressure_compensation_tb.sv =====
// Testbench for the barometric pressure compensation pipeline: directed and random readings,
// checked against an in-bench compensation predictor under random idling on both channels.
// Depends on bpc_pkg and the barometric_pressure_compensation top level.
`timescale 1ns / 1ps

module barometric_pressure_compensation_tb;

	localparam int LATENCY = 72;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	bpc_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	bpc_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	// Calibration copy held by the predictor.
	logic [63:0] cal_a, cal_b;
	logic [31:0] cal_c;
	logic [1:0] cal_oss;

	bpc_pkg::out_item_t pending_results[$];
	int error_count = 0;
	longint cycle_count = 0;

	barometric_pressure_compensation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Truncating signed division, as C does it.
	function automatic longint tdiv(input longint n, input longint d);
		longint q;
		q = n / d;
		return q;
	endfunction

	// Compensated temperature and pressure for one raw reading.
	function automatic bpc_pkg::out_item_t compensate(input bpc_pkg::in_item_t r);
		bpc_pkg::out_item_t o;
		longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		longint ut, up, x1, x2, x3, b3, b5, b6, p, t, sq;
		logic [31:0] b4, b7, scale;
		logic [23:0] raw;
		ac1 = longint'($signed(cal_a[15:0]));
		ac2 = longint'($signed(cal_a[31:16]));
		ac3 = longint'($signed(cal_a[47:32]));
		ac4 = longint'(cal_a[63:48]);
		ac5 = longint'(cal_b[15:0]);
		ac6 = longint'(cal_b[31:16]);
		b1 = longint'($signed(cal_b[47:32]));
		b2 = longint'($signed(cal_b[63:48]));
		mc = longint'($signed(cal_c[15:0]));
		md = longint'($signed(cal_c[31:16]));
		o = '0;
		ut = longint'(r.temp_raw);
		raw = {r.press_msb, r.press_lsb, r.press_xlsb};
		up = longint'(raw >> (8 - cal_oss));
		x1 = tdiv((ut - ac6) * ac5, 32768);
		if (x1 + md == 0) begin
			o.div_fault = 1'b1;
			return o;
		end
		x2 = tdiv(mc * 2048, x1 + md);
		b5 = x1 + x2;
		t = tdiv(b5 + 8, 16);
		b6 = b5 - bpc_pkg::TEMP_OFFSET;
		sq = tdiv(b6 * b6, 4096);
		x1 = tdiv(b2 * sq, 2048);
		x2 = tdiv(ac2 * b6, 2048);
		x3 = x1 + x2;
		b3 = tdiv((ac1 * 4 + x3) * (longint'(1) << cal_oss) + 2, 4);
		x1 = tdiv(ac3 * b6, 8192);
		x2 = tdiv(b1 * sq, 65536);
		x3 = tdiv(x1 + x2 + 2, 4);
		b4 = (32'(ac4) * 32'(x3 + bpc_pkg::X3_BIAS)) >> 15;
		if (b4 == 32'd0) begin
			o.div_fault = 1'b1;
			return o;
		end
		scale = 32'(bpc_pkg::SCALE_BASE) >> cal_oss;
		b7 = (32'(up) - 32'(b3)) * scale;
		if (b7 < 32'h8000_0000)
			p = longint'((64'(b7) * 2) / 64'(b4));
		else
			p = longint'(64'(b7 / b4) * 2);
		x1 = tdiv(p, 256) * tdiv(p, 256);
		x1 = tdiv(x1 * bpc_pkg::P_C1, 65536);
		x2 = tdiv(-bpc_pkg::P_C2 * p, 65536);
		p = p + tdiv(x1 + x2 + bpc_pkg::P_C3, 16);
		if (t > bpc_pkg::TEMP_MAX) t = bpc_pkg::TEMP_MAX;
		if (t < bpc_pkg::TEMP_MIN) t = bpc_pkg::TEMP_MIN;
		if (p > bpc_pkg::PRESS_MAX) p = bpc_pkg::PRESS_MAX;
		if (p < 0) p = 0;
		o.temp_tenths = 16'(t);
		o.press_pascal = 20'(p);
		return o;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	// Random gap length, mostly short, sometimes long.
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		bpc_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.temp_tenths !== want.temp_tenths)
					report_mismatch("temp_tenths", out_data.temp_tenths, want.temp_tenths);
				if (out_data.press_pascal !== want.press_pascal)
					report_mismatch("press_pascal", out_data.press_pascal, want.press_pascal);
				if (out_data.div_fault !== want.div_fault)
					report_mismatch("div_fault", out_data.div_fault, want.div_fault);
			end
		end
	end

	// Receiver stall: random gaps with quiet stretches.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = $urandom_range(1, 40);
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Sends one request and records its expected result. The request stays valid
	// afterwards so that the next one can follow without a gap.
	task automatic send_reading(input bpc_pkg::in_item_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(compensate(r));
	endtask

	// Waits until every request has produced its result, then lets the pipe empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// Writes one configuration register while the block is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bpc_pkg::CFG_COEFF_A: cal_a = val;
			bpc_pkg::CFG_COEFF_B: cal_b = val;
			bpc_pkg::CFG_COEFF_C: cal_c = val[31:0];
			default: cal_oss = val[1:0];
		endcase
	endtask

	task automatic load_cal(input logic [63:0] a, input logic [63:0] b, input logic [31:0] c,
		input logic [1:0] oss);
		write_reg(bpc_pkg::CFG_COEFF_A, a);
		write_reg(bpc_pkg::CFG_COEFF_B, b);
		write_reg(bpc_pkg::CFG_COEFF_C, {32'h0, c});
		write_reg(bpc_pkg::CFG_OVERSAMPLING, {62'h0, oss});
		cfg_valid <= 1'b0;
	endtask

	function automatic bpc_pkg::in_item_t rand_reading();
		bpc_pkg::in_item_t r;
		r = 40'({$urandom, $urandom});
		return r;
	endfunction

	// Typical sensor calibration, packed lowest first.
	function automatic logic [63:0] typ_a();
		return {16'd32741, -16'sd14383, -16'sd1151, 16'sd408};
	endfunction
	function automatic logic [63:0] typ_b();
		return {16'sd4, 16'sd6190, 16'd23153, 16'd32757};
	endfunction
	function automatic logic [31:0] typ_c();
		return {16'sd2868, -16'sd8711};
	endfunction

	// Reset calibration: all-zero and all-one readings with zero registers hit the zero temperature divisor.
	task automatic test_reset_values();
		send_reading('0);
		send_reading('1);
		drain();
	endtask

	// Directed readings at field extremes and the special cases.
	task automatic test_directed();
		logic [1:0] oss;
		logic [63:0] ta, tb;
		logic [31:0] tc;
		ta = typ_a();
		tb = typ_b();
		tc = typ_c();
		for (int k = 0; k < 4; k++) begin
			oss = 2'(k);
			load_cal(ta, tb, tc, oss);
			send_reading({16'd27898, 8'h5D, 8'h23, 8'h00});
			send_reading('0);
			send_reading('1);
			send_reading({16'hFFFF, 8'h00, 8'h00, 8'h00});
			drain();
		end
		// Zero temperature divisor: md = 0 and x1 = 0 with ac5 = 0.
		load_cal(ta, {tb[63:16], 16'd0}, {16'd0, 16'd100}, 2'd0);
		send_reading({16'd1234, 8'h50, 8'h00, 8'h00});
		drain();
		// Zero pressure divisor: ac4 = 0.
		load_cal({16'd0, ta[47:0]}, tb, tc, 2'd1);
		send_reading({16'd27898, 8'h5D, 8'h23, 8'h00});
		drain();
		// Saturation extremes and raw below B3.
		load_cal({16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF},
			{16'h0001, 16'h7FFF}, 2'd3);
		send_reading('0);
		send_reading('1);
		drain();
		load_cal({16'd1, 16'h8000, 16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF, 16'd0, 16'd1},
			{16'hFFFF, 16'h8000}, 2'd0);
		send_reading('0);
		send_reading('1);
		drain();
	endtask

	// Random readings over several calibrations, typical and random.
	task automatic test_random();
		for (int ph = 0; ph < 16; ph++) begin
			if (ph % 2 == 0)
				load_cal(typ_a() ^ 64'($urandom_range(0, 255)), typ_b(),
					typ_c() ^ 32'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
			else
				load_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
					2'($urandom_range(0, 3)));
			for (int i = 0; i < 100; i++) begin
				send_reading(rand_reading());
				// Sender waits once for every outstanding result.
				if (ph == 3 && i == 50) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = bpc_pkg::CFG_COEFF_A;
		cfg_data = '0;
		cal_a = '0;
		cal_b = '0;
		cal_c = '0;
		cal_oss = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_random();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
